### rtl/core/ssme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssme_pkg
// shared types and constants for the schedule makespan evaluator
// ----------------------------------------------------------------------------
package ssme_pkg;

    localparam int MACHINES  = 16;
    localparam int JOBS      = 64;
    localparam int MACH_W    = 4;
    localparam int JOB_W     = 6;
    localparam int TIME_W    = 32;
    localparam int MACH_AW   = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int JOB_AW    = (JOBS > 1) ? $clog2(JOBS) : 1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [MACH_AW-1:0] mach_idx_t;
    typedef logic [JOB_AW-1:0]  job_idx_t;

    typedef struct packed {
        logic              start_schedule;
        logic [JOB_W-1:0]  job;
        logic [MACH_W-1:0] machine;
        logic              first_of_job;
        time_t             proc_time;
    } op_word_t;

    typedef struct packed {
        time_t done_time;
        logic  pred_is_job;
        time_t makespan;
    } res_word_t;

    // control from the store side to the timing unit
    typedef struct packed {
        logic start;
        logic first;
        logic mach_seen;
        logic fwd_mach;
        logic fwd_job;
    } calc_ctrl_t;

endpackage

### rtl/core/ssme_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssme_calc
// start selection, saturating completion time and running makespan
// ----------------------------------------------------------------------------
module ssme_calc
(
    input  ssme_pkg::calc_ctrl_t ctrl,
    input  ssme_pkg::time_t      mach_rd,
    input  ssme_pkg::time_t      job_rd,
    input  ssme_pkg::time_t      last_done,
    input  ssme_pkg::time_t      proc_time,
    input  ssme_pkg::time_t      makespan_now,
    output ssme_pkg::res_word_t  res
);
    import ssme_pkg::*;

    time_t             mach_t;
    time_t             job_t;
    time_t             begin_t;
    time_t             ms_base;
    logic              by_job;
    logic [TIME_W:0]   sum;

    always_comb
    begin
        if (ctrl.start)
            mach_t = '0;
        else if (ctrl.fwd_mach)
            mach_t = last_done;
        else if (ctrl.mach_seen)
            mach_t = mach_rd;
        else
            mach_t = '0;

        job_t   = ctrl.fwd_job ? last_done : job_rd;
        by_job  = !ctrl.first && (mach_t < job_t);
        begin_t = by_job ? job_t : mach_t;
        sum     = {1'b0, begin_t} + {1'b0, proc_time};

        res.done_time   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        res.pred_is_job = by_job;
        ms_base         = ctrl.start ? '0 : makespan_now;
        res.makespan    = (res.done_time > ms_base) ? res.done_time : ms_base;
    end

endmodule

### rtl/core/shop_schedule_makespan_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shop_schedule_makespan_eval_top
// makespan evaluator for a shop schedule fed one operation per word
// ----------------------------------------------------------------------------
// One operation word is taken per cycle while the input is not stalled. The
// accepting edge also does the synchronous read of the machine and job time
// memories. The compute stage then does the compare, the saturating add and the
// makespan update, and the result is registered when that stage advances.
// The input stalls only while a result word waits in the output register and
// the compute stage is full. Back-to-back operations on the same machine or
// job are served by forwarding the last written time. A schedule start clears
// the machine times at once through per-machine valid bits. Job times are
// undefined until a job's first operation writes them.
module shop_schedule_makespan_eval_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    output logic                 op_stall,
    input  ssme_pkg::op_word_t   op_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output ssme_pkg::res_word_t  res_word
);
    import ssme_pkg::*;

    time_t               mach_mem [MACHINES];
    time_t               job_mem  [JOBS];

    time_t               mach_rd_reg;
    time_t               job_rd_reg;
    logic                s1_valid_reg;
    op_word_t            s1_word_reg;
    logic                fwd_mach_reg;
    logic                fwd_job_reg;
    time_t               last_done_reg;
    logic [MACHINES-1:0] seen_reg;
    logic [MACHINES-1:0] seen_next;
    time_t               makespan_reg;
    logic                res_valid_reg;
    res_word_t           res_word_reg;

    logic                advance;
    logic                op_take;
    mach_idx_t           op_m;
    job_idx_t            op_j;
    mach_idx_t           s1_m;
    job_idx_t            s1_j;
    calc_ctrl_t          ctrl;
    res_word_t           calc_res;

    assign op_m     = op_word.machine[MACH_AW-1:0];
    assign op_j     = op_word.job[JOB_AW-1:0];
    assign s1_m     = s1_word_reg.machine[MACH_AW-1:0];
    assign s1_j     = s1_word_reg.job[JOB_AW-1:0];

    assign advance  = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign op_stall = s1_valid_reg && !advance;
    assign op_take  = op_valid && !op_stall;

    assign ctrl.start     = s1_word_reg.start_schedule;
    assign ctrl.first     = s1_word_reg.first_of_job;
    assign ctrl.mach_seen = seen_reg[s1_m];
    assign ctrl.fwd_mach  = fwd_mach_reg;
    assign ctrl.fwd_job   = fwd_job_reg;

    ssme_calc u_calc
    (
        .ctrl         (ctrl),
        .mach_rd      (mach_rd_reg),
        .job_rd       (job_rd_reg),
        .last_done    (last_done_reg),
        .proc_time    (s1_word_reg.proc_time),
        .makespan_now (makespan_reg),
        .res          (calc_res)
    );

    // time memories, read before write on the same edge
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mach_mem[s1_m] <= calc_res.done_time;
            job_mem[s1_j]  <= calc_res.done_time;
        end
        if (op_take)
        begin
            mach_rd_reg <= mach_mem[op_m];
            job_rd_reg  <= job_mem[op_j];
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (advance)
        begin
            if (s1_word_reg.start_schedule)
                seen_next = '0;
            seen_next[s1_m] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            seen_reg      <= '0;
            makespan_reg  <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (op_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                makespan_reg  <= calc_res.makespan;
            end
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            s1_word_reg  <= op_word;
            fwd_mach_reg <= advance && (s1_m == op_m);
            fwd_job_reg  <= advance && (s1_j == op_j);
        end
        if (advance)
        begin
            last_done_reg <= calc_res.done_time;
            res_word_reg  <= calc_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

### rtl/core/ssme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssme_checker
// port-level checks for the schedule makespan evaluator
// ----------------------------------------------------------------------------
module ssme_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 op_valid,
    input logic                 op_stall,
    input ssme_pkg::op_word_t   op_word,
    input logic                 res_valid,
    input logic                 res_stall,
    input ssme_pkg::res_word_t  res_word
);
    import ssme_pkg::*;

    // a held operation word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_stall |=> op_valid && $stable(op_word))
    else $error("operation word changed while stalled");

    // a held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("result word changed while stalled");

    // the input only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> res_valid && res_stall)
    else $error("input stalled with free output");

    // makespan covers every completion time
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_word.makespan >= res_word.done_time)
    else $error("makespan below completion time");

    // an infeasible operation makes the schedule infeasible
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.done_time == TIME_MAX) |-> res_word.makespan == TIME_MAX)
    else $error("saturated completion not in makespan");

endmodule

bind shop_schedule_makespan_eval_top ssme_checker u_ssme_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op_word   (op_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);
